// File: hdl/pal_pkg.sv
// ----------------------------------------------------------------------------
// pal_pkg: shared types and constants of the positional array list
// Sizes, request kinds, status codes and the command broadcast to the cells.
// ----------------------------------------------------------------------------
`default_nettype none

package pal_pkg;

	// Storage geometry.
	localparam int DEPTH  = 16;
	localparam int ELEM_W = 8;
	localparam int IDX_W  = $clog2(DEPTH);
	localparam int CNT_W  = $clog2(DEPTH + 1);
	localparam int KIND_W = 3;
	localparam int STAT_W = 2;

	// Request kinds; the two unused codes fall to a default arm.
	typedef enum logic [KIND_W-1:0] {
		KIND_APPEND = 3'd0,
		KIND_INSERT = 3'd1,
		KIND_EDIT   = 3'd2,
		KIND_DELETE = 3'd3,
		KIND_GET    = 3'd4,
		KIND_SEARCH = 3'd5
	} kind_t;

	// Result status codes.
	typedef enum logic [STAT_W-1:0] {
		ST_OK        = 2'd0,
		ST_RANGE     = 2'd1,
		ST_FULL      = 2'd2,
		ST_NOT_FOUND = 2'd3
	} status_t;

	// Operation applied by every cell in the same cycle.
	typedef enum logic [1:0] {
		CELL_HOLD   = 2'd0,
		CELL_WRITE  = 2'd1,
		CELL_INSERT = 2'd2,
		CELL_DELETE = 2'd3
	} cell_op_t;

	// Command broadcast along the row of cells.
	typedef struct packed {
		cell_op_t          op;
		logic [IDX_W-1:0]  pos;
		logic [ELEM_W-1:0] value;
		logic [CNT_W-1:0]  cnt;
	} cell_cmd_t;

endpackage

`default_nettype wire

// File: hdl/pal_if.sv
// ----------------------------------------------------------------------------
// pal_if: request and response channels of the positional array list
// Valid/ready channels; a beat moves when valid and ready are both high.
// ----------------------------------------------------------------------------
`default_nettype none

interface pal_req_if;
	logic                           valid;
	logic                           ready;
	logic [pal_pkg::KIND_W-1:0]     kind;
	logic [pal_pkg::IDX_W-1:0]      position;
	logic [pal_pkg::ELEM_W-1:0]     value;

	modport source (output valid, kind, position, value, input ready);
	modport sink   (input valid, kind, position, value, output ready);
endinterface

interface pal_resp_if;
	logic                           valid;
	logic                           ready;
	logic [pal_pkg::STAT_W-1:0]     status;
	logic [pal_pkg::ELEM_W-1:0]     read_value;
	logic [pal_pkg::IDX_W-1:0]      found_index;
	logic [pal_pkg::CNT_W-1:0]      entry_count;
	logic                           is_full;
	logic                           is_empty;

	modport source (output valid, status, read_value, found_index, entry_count,
		is_full, is_empty, input ready);
	modport sink   (input valid, status, read_value, found_index, entry_count,
		is_full, is_empty, output ready);
endinterface

`default_nettype wire

// File: hdl/positional_array_list.sv
// ----------------------------------------------------------------------------
// positional_array_list: bounded ordered list with insert, delete and search
// A row of entry cells shifts in parallel; one request is served per beat.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Contents
//   req       in         kind, position, value
//   resp      out        status, read_value, found_index, entry_count,
//                        is_full, is_empty
//   cfg       in         capacity_limit (write only)
//
// Each request is decided in the cycle it is accepted and its response sits
// in the output register on the next cycle, so one beat per cycle is taken
// while the response side keeps up. The row of cells shifts and compares in
// parallel, which sets that figure. A stalled response holds the request
// side until it is taken. Reset empties the list and sets the capacity to 16.
// ----------------------------------------------------------------------------
`default_nettype none

module positional_array_list (
	input  logic                        clk,
	input  logic                        arst_n,
	pal_req_if.sink                     req,
	pal_resp_if.source                  resp,
	input  logic                        cfg_wr_en,
	input  logic [pal_pkg::CNT_W-1:0]   cfg_wr_data
);
	import pal_pkg::*;

	logic [CNT_W-1:0]  cap_q;
	logic [CNT_W-1:0]  count_q;
	logic [CNT_W-1:0]  cap_eff;
	logic [CNT_W-1:0]  count_nxt;
	logic [CNT_W-1:0]  pos_ext;
	logic              full;
	logic              accept;
	cell_op_t          op;
	cell_cmd_t         cmd;
	status_t           status;
	logic [ELEM_W-1:0] rd;
	logic [IDX_W-1:0]  fidx;
	logic              found;
	logic [ELEM_W-1:0] cell_data [DEPTH];
	logic [DEPTH-1:0]  cell_match;

	logic              out_valid_q;
	status_t           status_q;
	logic [ELEM_W-1:0] rd_q;
	logic [IDX_W-1:0]  fidx_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              full_q;
	logic              empty_q;

	// Accept a request whenever the output register is free or draining.
	assign req.ready = !out_valid_q || resp.ready;
	assign accept    = req.valid && req.ready;

	// Effective capacity: zero counts as one, larger values saturate.
	always_comb begin
		if (cap_q == '0) begin
			cap_eff = CNT_W'(1);
		end else if (cap_q > CNT_W'(DEPTH)) begin
			cap_eff = CNT_W'(DEPTH);
		end else begin
			cap_eff = cap_q;
		end
	end

	assign full    = count_q >= cap_eff;
	assign pos_ext = CNT_W'(req.position);

	// Lowest matching index among the live entries.
	always_comb begin
		found = 1'b0;
		fidx  = '0;
		for (int i = DEPTH - 1; i >= 0; i--) begin
			if (cell_match[i]) begin
				found = 1'b1;
				fidx  = IDX_W'(i);
			end
		end
	end

	// Request decode: status, read data, new count and the cell operation.
	always_comb begin
		op        = CELL_HOLD;
		status    = ST_OK;
		rd        = '0;
		count_nxt = count_q;
		case (kind_t'(req.kind))
			KIND_APPEND: begin
				if (full) begin
					status = ST_FULL;
				end else begin
					op        = CELL_WRITE;
					count_nxt = count_q + CNT_W'(1);
				end
			end
			KIND_INSERT: begin
				if (pos_ext > count_q) begin
					status = ST_RANGE;
				end else if (full) begin
					status = ST_FULL;
				end else begin
					op        = CELL_INSERT;
					count_nxt = count_q + CNT_W'(1);
				end
			end
			KIND_EDIT: begin
				if (pos_ext >= count_q) begin
					status = ST_RANGE;
				end else begin
					op = CELL_WRITE;
				end
			end
			KIND_DELETE: begin
				if (pos_ext >= count_q) begin
					status = ST_RANGE;
				end else begin
					op        = CELL_DELETE;
					count_nxt = count_q - CNT_W'(1);
				end
			end
			KIND_GET: begin
				if (pos_ext >= count_q) begin
					status = ST_RANGE;
				end else begin
					rd = cell_data[req.position];
				end
			end
			KIND_SEARCH: begin
				if (!found) begin
					status = ST_NOT_FOUND;
				end
			end
			default: begin
				status = ST_OK;
			end
		endcase
	end

	// Command to the row; an append writes at the current count.
	always_comb begin
		cmd.op    = accept ? op : CELL_HOLD;
		cmd.pos   = (kind_t'(req.kind) == KIND_APPEND) ? count_q[IDX_W-1:0] : req.position;
		cmd.value = req.value;
		cmd.cnt   = count_q;
	end

	// Row of entry cells, each linked to its lower and upper neighbor.
	for (genvar g = 0; g < DEPTH; g++) begin : g_cell
		logic [ELEM_W-1:0] lo;
		logic [ELEM_W-1:0] hi;

		if (g == 0) begin : g_first
			assign lo = '0;
		end else begin : g_lower
			assign lo = cell_data[g-1];
		end
		if (g == DEPTH - 1) begin : g_last
			assign hi = '0;
		end else begin : g_upper
			assign hi = cell_data[g+1];
		end

		pal_cell u_cell (
			.clk     (clk),
			.idx     (IDX_W'(g)),
			.cmd     (cmd),
			.data_lo (lo),
			.data_hi (hi),
			.data    (cell_data[g]),
			.match   (cell_match[g])
		);
	end

	// Count and capacity registers; a capacity write empties the list.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			cap_q   <= CNT_W'(DEPTH);
		end else if (cfg_wr_en) begin
			count_q <= '0;
			cap_q   <= cfg_wr_data;
		end else if (accept) begin
			count_q <= count_nxt;
		end
	end

	// Output valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= 1'b1;
		end else if (resp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output payload register.
	always_ff @(posedge clk) begin
		if (accept) begin
			status_q <= status;
			rd_q     <= rd;
			fidx_q   <= (kind_t'(req.kind) == KIND_SEARCH && found) ? fidx : '0;
			cnt_q    <= count_nxt;
			full_q   <= count_nxt == cap_eff;
			empty_q  <= count_nxt == '0;
		end
	end

	assign resp.valid       = out_valid_q;
	assign resp.status      = status_q;
	assign resp.read_value  = rd_q;
	assign resp.found_index = fidx_q;
	assign resp.entry_count = cnt_q;
	assign resp.is_full     = full_q;
	assign resp.is_empty    = empty_q;

endmodule

`default_nettype wire

// File: hdl/pal_cell.sv
// ----------------------------------------------------------------------------
// pal_cell: one entry of the list
// Holds one element, takes it from a neighbor on insert or delete, and
// reports whether it matches the search key while inside the live range.
// ----------------------------------------------------------------------------
`default_nettype none

module pal_cell (
	input  logic                        clk,
	input  logic [pal_pkg::IDX_W-1:0]   idx,
	input  pal_pkg::cell_cmd_t          cmd,
	input  logic [pal_pkg::ELEM_W-1:0]  data_lo,
	input  logic [pal_pkg::ELEM_W-1:0]  data_hi,
	output logic [pal_pkg::ELEM_W-1:0]  data,
	output logic                        match
);
	import pal_pkg::*;

	logic [ELEM_W-1:0] data_q;

	// Entry update: write at the position, or shift with the neighbors.
	always_ff @(posedge clk) begin
		case (cmd.op)
			CELL_WRITE: begin
				if (idx == cmd.pos) begin
					data_q <= cmd.value;
				end
			end
			CELL_INSERT: begin
				if (idx == cmd.pos) begin
					data_q <= cmd.value;
				end else if (idx > cmd.pos) begin
					data_q <= data_lo;
				end
			end
			CELL_DELETE: begin
				if (idx >= cmd.pos) begin
					data_q <= data_hi;
				end
			end
			default: begin
				data_q <= data_q;
			end
		endcase
	end

	// Only entries below the count take part in a search.
	assign match = (data_q == cmd.value) && (CNT_W'(idx) < cmd.cnt);
	assign data  = data_q;

endmodule

`default_nettype wire

// File: sim/pal_checker.sv
// ----------------------------------------------------------------------------
// pal_checker: response scoreboard for the positional array list
// Watches the request, response and capacity ports, keeps a shadow copy of the
// list, works out the response each accepted request must get and compares
// every response beat with the oldest one still waiting.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pal_checker (
	input  logic                      clk,
	input  logic                      arst_n,
	pal_req_if                        req,
	pal_resp_if                       resp,
	input  logic                      cfg_wr_en,
	input  logic [pal_pkg::CNT_W-1:0] cfg_wr_data,
	output int                        fail_count,
	output int                        awaited_count
);
	import pal_pkg::*;

	// One response beat, field by field.
	typedef struct packed {
		status_t           status;
		logic [ELEM_W-1:0] read_value;
		logic [IDX_W-1:0]  found_index;
		logic [CNT_W-1:0]  entry_count;
		logic              is_full;
		logic              is_empty;
	} list_result_t;

	// Shadow copy of the list and its capacity register.
	logic [ELEM_W-1:0] shadow_entries [DEPTH];
	logic [CNT_W-1:0]  shadow_count;
	logic [CNT_W-1:0]  shadow_capacity;
	list_result_t      awaited_results [$];
	list_result_t      seen_result;

	// A capacity of zero acts as one; anything above the depth saturates.
	function automatic logic [CNT_W-1:0] usable_capacity();
		if (shadow_capacity == '0)
			return CNT_W'(1);
		if (shadow_capacity > CNT_W'(DEPTH))
			return CNT_W'(DEPTH);
		return shadow_capacity;
	endfunction

	// Apply one request to the shadow list and return the response it earns.
	function automatic list_result_t apply_request(logic [KIND_W-1:0] kind,
		logic [IDX_W-1:0] pos, logic [ELEM_W-1:0] val);
		list_result_t      res;
		logic [CNT_W-1:0]  cap;
		logic              hit;
		int                j;
		res = '0;
		res.status = ST_OK;
		cap = usable_capacity();
		case (kind_t'(kind))
			KIND_APPEND: begin
				if (shadow_count >= cap)
					res.status = ST_FULL;
				else begin
					shadow_entries[shadow_count[IDX_W-1:0]] = val;
					shadow_count = shadow_count + 1'b1;
				end
			end
			KIND_INSERT: begin
				// Range is checked before fullness.
				if (CNT_W'(pos) > shadow_count)
					res.status = ST_RANGE;
				else if (shadow_count >= cap)
					res.status = ST_FULL;
				else begin
					for (j = int'(shadow_count); j > int'(pos); j--)
						shadow_entries[j] = shadow_entries[j-1];
					shadow_entries[pos] = val;
					shadow_count = shadow_count + 1'b1;
				end
			end
			KIND_EDIT: begin
				if (CNT_W'(pos) >= shadow_count)
					res.status = ST_RANGE;
				else
					shadow_entries[pos] = val;
			end
			KIND_DELETE: begin
				if (CNT_W'(pos) >= shadow_count)
					res.status = ST_RANGE;
				else begin
					for (j = int'(pos); j + 1 < int'(shadow_count); j++)
						shadow_entries[j] = shadow_entries[j+1];
					shadow_count = shadow_count - 1'b1;
				end
			end
			KIND_GET: begin
				if (CNT_W'(pos) >= shadow_count)
					res.status = ST_RANGE;
				else
					res.read_value = shadow_entries[pos];
			end
			KIND_SEARCH: begin
				// The lowest matching index wins.
				res.status = ST_NOT_FOUND;
				hit = 1'b0;
				for (j = 0; j < int'(shadow_count); j++) begin
					if (!hit && shadow_entries[j] == val) begin
						hit = 1'b1;
						res.status = ST_OK;
						res.found_index = IDX_W'(j);
					end
				end
			end
			default: begin
				// Unused kinds leave the list alone and report success.
			end
		endcase
		res.entry_count = shadow_count;
		res.is_full = (shadow_count == cap);
		res.is_empty = (shadow_count == '0);
		return res;
	endfunction

	// Print one line per mismatch and count it.
	task automatic report_mismatch(string msg);
		$display("[%0t] mismatch: %s", $realtime, msg);
		fail_count++;
	endtask

	task automatic compare_result(list_result_t got, list_result_t want);
		if (got.status !== want.status)
			report_mismatch($sformatf("status got %0d want %0d",
				got.status, want.status));
		if (got.read_value !== want.read_value)
			report_mismatch($sformatf("read_value got %0d want %0d",
				got.read_value, want.read_value));
		if (got.found_index !== want.found_index)
			report_mismatch($sformatf("found_index got %0d want %0d",
				got.found_index, want.found_index));
		if (got.entry_count !== want.entry_count)
			report_mismatch($sformatf("entry_count got %0d want %0d",
				got.entry_count, want.entry_count));
		if (got.is_full !== want.is_full)
			report_mismatch($sformatf("is_full got %0b want %0b",
				got.is_full, want.is_full));
		if (got.is_empty !== want.is_empty)
			report_mismatch($sformatf("is_empty got %0b want %0b",
				got.is_empty, want.is_empty));
	endtask

	// Responses are checked before the request of the same edge is applied,
	// since a response always belongs to an earlier request.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shadow_count = '0;
			shadow_capacity = CNT_W'(DEPTH);
			awaited_results.delete();
			awaited_count = 0;
		end else begin
			if (resp.valid === 1'b1 && resp.ready === 1'b1) begin
				seen_result.status = status_t'(resp.status);
				seen_result.read_value = resp.read_value;
				seen_result.found_index = resp.found_index;
				seen_result.entry_count = resp.entry_count;
				seen_result.is_full = resp.is_full;
				seen_result.is_empty = resp.is_empty;
				if (awaited_results.size() == 0)
					report_mismatch("response beat with no request waiting");
				else
					compare_result(seen_result, awaited_results.pop_front());
			end
			if (cfg_wr_en === 1'b1) begin
				shadow_capacity = cfg_wr_data;
				shadow_count = '0;
			end
			if (req.valid === 1'b1 && req.ready === 1'b1)
				awaited_results.push_back(apply_request(req.kind, req.position, req.value));
			awaited_count = awaited_results.size();
		end
	end

endmodule

`default_nettype wire

// File: sim/testbench.sv
// ----------------------------------------------------------------------------
// testbench: stimulus and verdict for the positional array list
// Runs the list through a series of capacity settings, each followed by
// random requests (directed ones first in phases 0 and 1) with random gaps
// on both channels, while the scoreboard beside the block checks every response.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module testbench;
	import pal_pkg::*;

	localparam int CLK_HALF     = 10;
	localparam int CYCLE_LIMIT  = 300000;
	localparam int DRAIN_CYCLES = 4;
	localparam int NUM_PHASES   = 8;
	localparam int STRETCH_LEN  = 40;
	localparam int FIRST_SPARE_KIND = 6;
	localparam int LAST_SPARE_KIND  = 2**KIND_W - 1;

	// Capacity settings and random request counts, one pair per phase.
	localparam logic [CNT_W-1:0] PHASE_CAPACITY [NUM_PHASES] =
		'{5'd16, 5'd1, 5'd0, 5'd31, 5'd3, 5'd8, 5'd17, 5'd16};
	localparam int PHASE_ITEMS [NUM_PHASES] =
		'{180, 110, 100, 200, 150, 150, 110, 100};

	logic             clk = 1'b0;
	logic             arst_n;
	logic             cfg_wr_en;
	logic [CNT_W-1:0] cfg_wr_data;
	int               fail_count;
	int               awaited_count;
	int               cycle_count = 0;

	// Rough occupancy used only to steer positions toward valid ones.
	int               fill_level = 0;
	int               fill_capacity = DEPTH;
	logic             sender_quiet = 1'b0;
	logic             ready_quiet = 1'b0;

	pal_req_if  req_ch ();
	pal_resp_if resp_ch ();

	positional_array_list dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.req         (req_ch),
		.resp        (resp_ch),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data)
	);

	pal_checker list_scoreboard (
		.clk           (clk),
		.arst_n        (arst_n),
		.req           (req_ch),
		.resp          (resp_ch),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_wr_data   (cfg_wr_data),
		.fail_count    (fail_count),
		.awaited_count (awaited_count)
	);

	always #CLK_HALF clk = ~clk;

	// Watchdog.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	// Response side: stall a random number of cycles before each beat,
	// with occasional stretches of no stalls at all.
	initial begin
		int stall;
		int beats;
		beats = 0;
		resp_ch.ready <= 1'b0;
		forever begin
			if (beats % STRETCH_LEN == 0)
				ready_quiet = ($urandom_range(0, 3) == 0);
			stall = ready_quiet ? 0 : $urandom_range(0, 4);
			if (stall > 0) begin
				resp_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			resp_ch.ready <= 1'b1;
			do @(posedge clk); while (resp_ch.valid !== 1'b1);
			beats++;
		end
	end

	// Wait until every response has arrived, then let the block settle.
	task automatic wait_drained();
		do @(negedge clk); while (awaited_count != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Send one request beat after a random gap and track the occupancy.
	task automatic send_request(logic [KIND_W-1:0] kind, logic [IDX_W-1:0] pos,
		logic [ELEM_W-1:0] val);
		int gap;
		gap = sender_quiet ? 0 : $urandom_range(0, 4);
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_ch.valid    <= 1'b1;
		req_ch.kind     <= kind;
		req_ch.position <= pos;
		req_ch.value    <= val;
		do @(posedge clk); while (req_ch.ready !== 1'b1);
		case (kind_t'(kind))
			KIND_APPEND:
				if (fill_level < fill_capacity)
					fill_level++;
			KIND_INSERT:
				if (int'(pos) <= fill_level && fill_level < fill_capacity)
					fill_level++;
			KIND_DELETE:
				if (int'(pos) < fill_level)
					fill_level--;
			default: begin
			end
		endcase
	endtask

	// Write the capacity register once the block is idle.
	task automatic set_capacity(logic [CNT_W-1:0] cap);
		req_ch.valid <= 1'b0;
		wait_drained();
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= cap;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		fill_level = 0;
		if (cap == '0)
			fill_capacity = 1;
		else if (int'(cap) > DEPTH)
			fill_capacity = DEPTH;
		else
			fill_capacity = int'(cap);
	endtask

	// Mostly positions that hit the live part of the list, sometimes any.
	function automatic logic [IDX_W-1:0] pick_position(logic [KIND_W-1:0] kind);
		if ($urandom_range(0, 3) == 0)
			return IDX_W'($urandom_range(0, DEPTH - 1));
		if (kind == KIND_INSERT)
			return IDX_W'($urandom_range(0, (fill_level < DEPTH) ? fill_level : DEPTH - 1));
		if (fill_level == 0)
			return '0;
		return IDX_W'($urandom_range(0, fill_level - 1));
	endfunction

	// Small values give duplicates and search hits; the rest spans the range.
	function automatic logic [ELEM_W-1:0] pick_value();
		if ($urandom_range(0, 2) == 0)
			return ELEM_W'($urandom_range(0, 2**ELEM_W - 1));
		return ELEM_W'($urandom_range(0, 7));
	endfunction

	// Random requests in stretches that either grow or shrink the list.
	task automatic run_random(int count);
		int               idx;
		int               pick;
		logic             growing;
		logic [KIND_W-1:0] kind;
		growing = 1'b1;
		for (idx = 0; idx < count; idx++) begin
			if (idx % STRETCH_LEN == 0) begin
				growing = $urandom_range(0, 1);
				sender_quiet = ($urandom_range(0, 3) == 0);
			end
			// Now and then hold off until the list has answered everything.
			if (idx == count / 2 || $urandom_range(0, 99) == 0) begin
				req_ch.valid <= 1'b0;
				wait_drained();
			end
			pick = $urandom_range(0, 99);
			if (pick < (growing ? 22 : 8))
				kind = KIND_APPEND;
			else if (pick < (growing ? 44 : 16))
				kind = KIND_INSERT;
			else if (pick < (growing ? 54 : 28))
				kind = KIND_EDIT;
			else if (pick < (growing ? 66 : 60))
				kind = KIND_DELETE;
			else if (pick < (growing ? 78 : 74))
				kind = KIND_GET;
			else if (pick < 96)
				kind = KIND_SEARCH;
			else
				kind = KIND_W'($urandom_range(FIRST_SPARE_KIND, LAST_SPARE_KIND));
			send_request(kind, pick_position(kind), pick_value());
		end
	endtask

	initial begin
		int phase;
		arst_n          <= 1'b0;
		cfg_wr_en       <= 1'b0;
		cfg_wr_data     <= '0;
		req_ch.valid    <= 1'b0;
		req_ch.kind     <= KIND_APPEND;
		req_ch.position <= '0;
		req_ch.value    <= '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (phase = 0; phase < NUM_PHASES; phase++) begin
			set_capacity(PHASE_CAPACITY[phase]);
			if (phase == 0) begin
				// Every access on the empty list is out of range or a miss.
				send_request(KIND_GET, 4'd0, 8'd0);
				send_request(KIND_DELETE, 4'd0, 8'd0);
				send_request(KIND_EDIT, 4'd15, 8'd255);
				send_request(KIND_SEARCH, 4'd0, 8'd0);
				send_request(KIND_INSERT, 4'd1, 8'd1);
				// Build a short list through both ends and the middle.
				send_request(KIND_INSERT, 4'd0, 8'hFF);
				send_request(KIND_APPEND, 4'd15, 8'h00);
				send_request(KIND_APPEND, 4'd0, 8'hAA);
				send_request(KIND_INSERT, 4'd3, 8'h55);
				send_request(KIND_INSERT, 4'd1, 8'h0F);
				send_request(KIND_GET, 4'd0, 8'd0);
				send_request(KIND_GET, 4'd4, 8'd0);
				send_request(KIND_GET, 4'd5, 8'd0);
				send_request(KIND_EDIT, 4'd2, 8'h80);
				send_request(KIND_SEARCH, 4'd0, 8'h80);
				send_request(KIND_SEARCH, 4'd15, 8'h77);
				send_request(KIND_DELETE, 4'd0, 8'd0);
				send_request(KIND_DELETE, 4'd3, 8'd0);
				send_request(KIND_W'(FIRST_SPARE_KIND), 4'd15, 8'hFF);
				send_request(KIND_W'(LAST_SPARE_KIND), 4'd0, 8'd0);
			end
			if (PHASE_CAPACITY[phase] == 5'd1 && phase == 1) begin
				// A full list refuses growth, but a bad insert position wins.
				send_request(KIND_APPEND, 4'd0, 8'h3C);
				send_request(KIND_APPEND, 4'd0, 8'h01);
				send_request(KIND_INSERT, 4'd0, 8'h02);
				send_request(KIND_INSERT, 4'd2, 8'h03);
				send_request(KIND_SEARCH, 4'd0, 8'h3C);
				send_request(KIND_DELETE, 4'd0, 8'd0);
			end
			run_random(PHASE_ITEMS[phase]);
		end

		req_ch.valid <= 1'b0;
		wait_drained();
		if (fail_count == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

`default_nettype wire
